@@ rtl/rnfp_pkg.sv @@
// ----------------------------------------------------------------------------
// RTP NAL packetizer package
// Shared widths, register reset values, byte constants and the command word
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package rnfp_pkg;

   localparam int MTU_W       = 14;
   localparam int LEN_W       = 24;
   localparam int TS_W        = 32;
   localparam int SSRC_W      = 32;
   localparam int PT_W        = 7;
   localparam int SEQ_W       = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   localparam logic [MTU_W-1:0]  MTU_RESET     = 14'd1200;
   localparam logic [PT_W-1:0]   PT_RESET      = 7'd96;
   localparam logic [SSRC_W-1:0] SSRC_RESET    = 32'h2110_2100;
   localparam logic [MTU_W-1:0]  MTU_FLOOR     = 14'd16;
   localparam logic [MTU_W-1:0]  RTP_HDR_BYTES = 14'd12;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MTU_BYTES        = 2'd0,
      CSR_PAYLOAD_TYPE     = 2'd1,
      CSR_STREAM_SOURCE_ID = 2'd2,
      CSR_H265_MODE        = 2'd3
   } csr_index_type;

   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [7:0] H264_NRI_MASK    = 8'he0;
   localparam logic [7:0] H264_FUA_TYPE    = 8'd28;
   localparam logic [7:0] H264_TYPE_MASK   = 8'h1f;
   localparam logic [7:0] H265_KEEP_MASK   = 8'h81;
   localparam logic [7:0] H265_FU_TYPE     = 8'd49;
   localparam logic [7:0] H265_TYPE_MASK   = 8'h7e;
   localparam logic [7:0] FU_START_BIT     = 8'h80;
   localparam logic [7:0] FU_END_BIT       = 8'h40;

   localparam int IDX_W = 4;
   localparam logic [IDX_W-1:0] IDX_FIRST_HDR = 4'd0;
   localparam logic [IDX_W-1:0] IDX_LAST_HDR  = 4'd11;
   localparam logic [IDX_W-1:0] IDX_FU_H265   = 4'd12;
   localparam logic [IDX_W-1:0] IDX_FU_H264   = 4'd13;
   localparam logic [IDX_W-1:0] IDX_FU_LAST   = 4'd14;
   localparam logic [IDX_W-1:0] IDX_PAYLOAD   = 4'd15;

   localparam int CMD_FIFO_DEPTH = 4;
   localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
   localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

   typedef struct packed {
      logic                  hdr;
      logic                  frag;
      logic                  h265;
      logic                  marker;
      logic [SEQ_W-1:0]      seq;
      logic [TS_W-1:0]       ts;
      logic [2:0][7:0]       fu;
      logic [7:0]            data;
      logic                  end_flag;
   } cmd_type;

   typedef struct packed {
      logic [MTU_W-1:0] mtu;
      logic             h265;
   } front_cfg_type;

   typedef struct packed {
      logic [PT_W-1:0]   pt;
      logic [SSRC_W-1:0] ssrc;
   } back_cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

@@ rtl/rnfp_front.sv @@
// ----------------------------------------------------------------------------
// RTP NAL packetizer front end
// Tracks the open NAL and packet, decides per byte whether a header and
// fragment header go before it, and issues one command word per payload byte.
// ----------------------------------------------------------------------------
module rnfp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic [7:0]                    req_nal_byte,
   input  logic                          req_nal_first,
   input  logic [rnfp_pkg::LEN_W-1:0]    req_nal_length,
   input  logic [rnfp_pkg::TS_W-1:0]     req_rtp_timestamp,
   input  logic                          req_end_of_frame,
   input  rnfp_pkg::front_cfg_type       cfg,
   input  rnfp_pkg::fifo_status_type     fifo_status,
   output logic                          cmd_push,
   output rnfp_pkg::cmd_type             cmd
);

   logic [rnfp_pkg::LEN_W-1:0] rem_ff, rem_in;
   logic [1:0]                 offc_ff, offc_in;
   logic [rnfp_pkg::MTU_W-1:0] pbl_ff, pbl_in;
   logic                       frag_ff, frag_in;
   logic                       h265_ff, h265_in;
   logic                       marker_ff, marker_in;
   logic [rnfp_pkg::TS_W-1:0]  ts_ff, ts_in;
   logic [rnfp_pkg::SEQ_W-1:0] seq_ff, seq_in;
   logic [7:0]                 fhb0_ff, fhb0_in;
   logic [7:0]                 fhb1_ff, fhb1_in;
   logic [7:0]                 fhb2_ff, fhb2_in;

   logic                       accept;
   logic [rnfp_pkg::MTU_W-1:0] mtu_eff;
   logic [rnfp_pkg::MTU_W-1:0] max_pay;
   logic [rnfp_pkg::MTU_W-1:0] room;
   logic [rnfp_pkg::MTU_W-1:0] chunk;
   logic [rnfp_pkg::LEN_W-1:0] rem;
   logic [1:0]                 offc;
   logic [1:0]                 hlen;
   logic [rnfp_pkg::MTU_W-1:0] pbl;
   logic                       frag;
   logic                       h265;
   logic                       marker;
   logic [rnfp_pkg::TS_W-1:0]  ts;
   logic                       fits;
   logic [7:0]                 fu_byte;

   always_comb begin
      accept  = req_push & ~fifo_status.full;
      mtu_eff = (cfg.mtu < rnfp_pkg::MTU_FLOOR) ? rnfp_pkg::MTU_FLOOR : cfg.mtu;
      max_pay = mtu_eff - rnfp_pkg::RTP_HDR_BYTES;

      rem    = req_nal_first ? req_nal_length : rem_ff;
      offc   = req_nal_first ? 2'd0 : offc_ff;
      pbl    = req_nal_first ? '0 : pbl_ff;
      frag   = req_nal_first ? (req_nal_length > {10'd0, max_pay}) : frag_ff;
      h265   = req_nal_first ? cfg.h265 : h265_ff;
      marker = req_nal_first ? req_end_of_frame : marker_ff;
      ts     = req_nal_first ? req_rtp_timestamp : ts_ff;

      hlen  = h265 ? 2'd2 : 2'd1;
      room  = max_pay - {12'd0, hlen} - 14'd1;
      fits  = rem <= {10'd0, room};
      chunk = fits ? rem[rnfp_pkg::MTU_W-1:0] : room;

      fu_byte = h265 ? fhb2_ff : fhb1_ff;
      if (offc == hlen) begin
         fu_byte = fu_byte | rnfp_pkg::FU_START_BIT;
      end
      if (fits) begin
         fu_byte = fu_byte | rnfp_pkg::FU_END_BIT;
      end

      rem_in    = rem_ff;
      offc_in   = offc_ff;
      pbl_in    = pbl_ff;
      frag_in   = frag_ff;
      h265_in   = h265_ff;
      marker_in = marker_ff;
      ts_in     = ts_ff;
      seq_in    = seq_ff;
      fhb0_in   = fhb0_ff;
      fhb1_in   = fhb1_ff;
      fhb2_in   = fhb2_ff;

      cmd_push     = 1'b0;
      cmd.hdr      = 1'b0;
      cmd.frag     = 1'b0;
      cmd.h265     = h265;
      cmd.marker   = marker;
      cmd.seq      = seq_ff;
      cmd.ts       = ts;
      cmd.fu[0]    = fhb0_ff;
      cmd.fu[1]    = h265 ? fhb1_ff : fhb0_ff;
      cmd.fu[2]    = fu_byte;
      cmd.data     = req_nal_byte;
      cmd.end_flag = 1'b0;

      if (accept) begin
         rem_in    = rem;
         offc_in   = offc;
         pbl_in    = pbl;
         frag_in   = frag;
         h265_in   = h265;
         marker_in = marker;
         ts_in     = ts;
         if (rem != '0) begin
            rem_in  = rem - 24'd1;
            offc_in = (offc == 2'd3) ? 2'd3 : offc + 2'd1;
            if (!frag) begin
               cmd_push     = 1'b1;
               cmd.hdr      = (offc == 2'd0);
               cmd.end_flag = (rem == 24'd1);
            end else if (offc == 2'd0) begin
               if (h265) begin
                  fhb0_in = (req_nal_byte & rnfp_pkg::H265_KEEP_MASK)
                          | {rnfp_pkg::H265_FU_TYPE[6:0], 1'b0};
                  fhb2_in = {1'b0, req_nal_byte[7:1] & rnfp_pkg::H265_TYPE_MASK[7:1]};
               end else begin
                  fhb0_in = (req_nal_byte & rnfp_pkg::H264_NRI_MASK)
                          | rnfp_pkg::H264_FUA_TYPE;
                  fhb1_in = req_nal_byte & rnfp_pkg::H264_TYPE_MASK;
               end
            end else if (offc < hlen) begin
               fhb1_in = req_nal_byte;
            end else begin
               cmd_push = 1'b1;
               if (pbl == '0) begin
                  cmd.hdr      = 1'b1;
                  cmd.frag     = 1'b1;
                  cmd.marker   = marker & fits;
                  pbl_in       = chunk - 14'd1;
                  cmd.end_flag = (chunk == 14'd1);
               end else begin
                  pbl_in       = pbl - 14'd1;
                  cmd.end_flag = (pbl == 14'd1);
               end
            end
            if (cmd.hdr) begin
               seq_in = seq_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= '0;
         offc_ff   <= '0;
         pbl_ff    <= '0;
         frag_ff   <= 1'b0;
         h265_ff   <= 1'b0;
         marker_ff <= 1'b0;
         ts_ff     <= '0;
         seq_ff    <= '0;
      end else begin
         rem_ff    <= rem_in;
         offc_ff   <= offc_in;
         pbl_ff    <= pbl_in;
         frag_ff   <= frag_in;
         h265_ff   <= h265_in;
         marker_ff <= marker_in;
         ts_ff     <= ts_in;
         seq_ff    <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      fhb0_ff <= fhb0_in;
      fhb1_ff <= fhb1_in;
      fhb2_ff <= fhb2_in;
   end

`ifndef ASSERT_OFF
   // An open fragment packet can only exist while a NAL is being fragmented.
   a_pbl_needs_frag: assert property (@(posedge clock) disable iff (reset)
      (pbl_ff != '0) |-> frag_ff)
      else $error("packet byte count set outside fragmentation");
`endif

endmodule

@@ rtl/rnfp_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// RTP NAL packetizer command queue
// A short queue of command words between the front end and the back end.
// ----------------------------------------------------------------------------
module rnfp_cmd_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rnfp_pkg::cmd_type         push_cmd,
   input  logic                      pop,
   output rnfp_pkg::cmd_type         head,
   output rnfp_pkg::fifo_status_type status
);

   rnfp_pkg::cmd_type mem [rnfp_pkg::CMD_FIFO_DEPTH];

   logic [rnfp_pkg::CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rnfp_pkg::CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rnfp_pkg::CMD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           do_push;
   logic                           do_pop;

   localparam logic [rnfp_pkg::CMD_PTR_W-1:0] PTR_LAST =
      rnfp_pkg::CMD_PTR_W'(rnfp_pkg::CMD_FIFO_DEPTH - 1);
   localparam logic [rnfp_pkg::CMD_CNT_W-1:0] CNT_FULL =
      rnfp_pkg::CMD_CNT_W'(rnfp_pkg::CMD_FIFO_DEPTH);

   always_comb begin
      status.full  = (cnt_ff == CNT_FULL);
      status.empty = (cnt_ff == '0);
      do_push      = push & ~status.full;
      do_pop       = pop & ~status.empty;
      head         = mem[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef ASSERT_OFF
   // The front end must never offer a command while the queue is full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("command pushed into a full queue");

   // The back end must never consume a command that is not there.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("command popped from an empty queue");
`endif

endmodule

@@ rtl/rnfp_back.sv @@
// ----------------------------------------------------------------------------
// RTP NAL packetizer back end
// Expands each command word into RTP header, fragment header and payload
// bytes, one byte per cycle when not stalled, into a single output register.
// ----------------------------------------------------------------------------
module rnfp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  rnfp_pkg::back_cfg_type    cfg,
   input  rnfp_pkg::fifo_status_type fifo_status,
   input  rnfp_pkg::cmd_type         head,
   output logic                      cmd_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [7:0]                rsp_packet_byte,
   output logic                      rsp_packet_end,
   output logic                      rsp_run_last
);

   logic                       in_cmd_ff, in_cmd_in;
   logic [rnfp_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       out_valid_ff, out_valid_in;
   logic [7:0]                 out_byte_ff, out_byte_in;
   logic                       out_end_ff, out_end_in;
   logic                       out_last_ff, out_last_in;

   logic                       load;
   logic [rnfp_pkg::IDX_W-1:0] idx_cur;
   logic [rnfp_pkg::IDX_W-1:0] idx_next;
   logic [7:0]                 cur_byte;

   always_comb begin
      load    = (~out_valid_ff | rsp_pop) & ~fifo_status.empty;
      idx_cur = in_cmd_ff ? idx_ff
              : (head.hdr ? rnfp_pkg::IDX_FIRST_HDR : rnfp_pkg::IDX_PAYLOAD);

      if (idx_cur == rnfp_pkg::IDX_LAST_HDR) begin
         if (head.frag) begin
            idx_next = head.h265 ? rnfp_pkg::IDX_FU_H265 : rnfp_pkg::IDX_FU_H264;
         end else begin
            idx_next = rnfp_pkg::IDX_PAYLOAD;
         end
      end else begin
         idx_next = idx_cur + 1'b1;
      end

      case (idx_cur)
         4'd0:                  cur_byte = rnfp_pkg::RTP_VERSION_BYTE;
         4'd1:                  cur_byte = {head.marker, cfg.pt};
         4'd2:                  cur_byte = head.seq[15:8];
         4'd3:                  cur_byte = head.seq[7:0];
         4'd4:                  cur_byte = head.ts[31:24];
         4'd5:                  cur_byte = head.ts[23:16];
         4'd6:                  cur_byte = head.ts[15:8];
         4'd7:                  cur_byte = head.ts[7:0];
         4'd8:                  cur_byte = cfg.ssrc[31:24];
         4'd9:                  cur_byte = cfg.ssrc[23:16];
         4'd10:                 cur_byte = cfg.ssrc[15:8];
         rnfp_pkg::IDX_LAST_HDR: cur_byte = cfg.ssrc[7:0];
         rnfp_pkg::IDX_FU_H265:  cur_byte = head.fu[0];
         rnfp_pkg::IDX_FU_H264:  cur_byte = head.fu[1];
         rnfp_pkg::IDX_FU_LAST:  cur_byte = head.fu[2];
         rnfp_pkg::IDX_PAYLOAD:  cur_byte = head.data;
         default:               cur_byte = head.data;
      endcase

      cmd_pop      = load & (idx_cur == rnfp_pkg::IDX_PAYLOAD);
      in_cmd_in    = in_cmd_ff;
      idx_in       = idx_ff;
      out_valid_in = load | (out_valid_ff & ~rsp_pop);
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         out_byte_in = cur_byte;
         out_end_in  = cmd_pop & head.end_flag;
         out_last_in = cmd_pop;
         in_cmd_in   = ~cmd_pop;
         idx_in      = idx_next;
      end

      rsp_empty       = ~out_valid_ff;
      rsp_packet_byte = out_byte_ff;
      rsp_packet_end  = out_end_ff;
      rsp_run_last    = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cmd_ff    <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_cmd_ff    <= in_cmd_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
      out_last_ff <= out_last_in;
   end

`ifndef ASSERT_OFF
   // A command stays at the queue head until its payload byte is loaded.
   a_cmd_held: assert property (@(posedge clock) disable iff (reset)
      in_cmd_ff |-> !fifo_status.empty)
      else $error("back end lost its command mid expansion");
`endif

endmodule

@@ rtl/rtp_nal_fragmenting_packetizer_unit.sv @@
// ----------------------------------------------------------------------------
// RTP NAL fragmenting packetizer
// Turns NAL unit bytes into RTP packet bytes, with single-packet or
// H.264 FU-A / H.265 FU fragmentation.
// ----------------------------------------------------------------------------
// The block accepts one NAL byte per cycle while not full and emits one packet
// byte per cycle while rsp_pop keeps up. A byte that carries only payload
// yields one output byte; a byte that opens a packet yields 13 output bytes
// for a single packet, 15 for an H.264 fragment and 16 for an H.265 fragment,
// since the back end sends the 12-byte RTP header and the two- or three-byte
// fragment header one byte per cycle before the payload byte. A four-entry
// command queue between the front end and the back end absorbs these bursts,
// and the input reports full while all four entries are taken. NAL header
// bytes that only feed the fragment header produce no output.
module rtp_nal_fragmenting_packetizer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [7:0]                          req_nal_byte,
   input  logic                                req_nal_first,
   input  logic [rnfp_pkg::LEN_W-1:0]          req_nal_length,
   input  logic [rnfp_pkg::TS_W-1:0]           req_rtp_timestamp,
   input  logic                                req_end_of_frame,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [7:0]                          rsp_packet_byte,
   output logic                                rsp_packet_end,
   output logic                                rsp_run_last,
   input  logic                                csr_wr_en,
   input  logic [rnfp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rnfp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [rnfp_pkg::MTU_W-1:0]  mtu_ff, mtu_in;
   logic [rnfp_pkg::PT_W-1:0]   pt_ff, pt_in;
   logic [rnfp_pkg::SSRC_W-1:0] ssrc_ff, ssrc_in;
   logic                        h265_ff, h265_in;

   rnfp_pkg::front_cfg_type   front_cfg;
   rnfp_pkg::back_cfg_type    back_cfg;
   rnfp_pkg::fifo_status_type fifo_status;
   rnfp_pkg::cmd_type         push_cmd;
   rnfp_pkg::cmd_type         head_cmd;
   logic                      cmd_push;
   logic                      cmd_pop;

   always_comb begin
      mtu_in  = mtu_ff;
      pt_in   = pt_ff;
      ssrc_in = ssrc_ff;
      h265_in = h265_ff;
      if (csr_wr_en) begin
         case (rnfp_pkg::csr_index_type'(csr_index))
            rnfp_pkg::CSR_MTU_BYTES:        mtu_in  = csr_wdata[rnfp_pkg::MTU_W-1:0];
            rnfp_pkg::CSR_PAYLOAD_TYPE:     pt_in   = csr_wdata[rnfp_pkg::PT_W-1:0];
            rnfp_pkg::CSR_STREAM_SOURCE_ID: ssrc_in = csr_wdata[rnfp_pkg::SSRC_W-1:0];
            rnfp_pkg::CSR_H265_MODE:        h265_in = csr_wdata[0];
            default:                        mtu_in  = mtu_ff;
         endcase
      end
      front_cfg.mtu  = mtu_ff;
      front_cfg.h265 = h265_ff;
      back_cfg.pt    = pt_ff;
      back_cfg.ssrc  = ssrc_ff;
      req_full       = fifo_status.full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff  <= rnfp_pkg::MTU_RESET;
         pt_ff   <= rnfp_pkg::PT_RESET;
         ssrc_ff <= rnfp_pkg::SSRC_RESET;
         h265_ff <= 1'b0;
      end else begin
         mtu_ff  <= mtu_in;
         pt_ff   <= pt_in;
         ssrc_ff <= ssrc_in;
         h265_ff <= h265_in;
      end
   end

   rnfp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_nal_byte      (req_nal_byte),
      .req_nal_first     (req_nal_first),
      .req_nal_length    (req_nal_length),
      .req_rtp_timestamp (req_rtp_timestamp),
      .req_end_of_frame  (req_end_of_frame),
      .cfg               (front_cfg),
      .fifo_status       (fifo_status),
      .cmd_push          (cmd_push),
      .cmd               (push_cmd)
   );

   rnfp_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .head     (head_cmd),
      .status   (fifo_status)
   );

   rnfp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (back_cfg),
      .fifo_status     (fifo_status),
      .head            (head_cmd),
      .cmd_pop         (cmd_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_packet_byte (rsp_packet_byte),
      .rsp_packet_end  (rsp_packet_end),
      .rsp_run_last    (rsp_run_last)
   );

endmodule
